[hw/rtl/mep_pkg.sv]
// Shared types, constants and helpers of the escape-time pixel engine.
`default_nettype none
package mep_pkg;

  // Image size defaults
  localparam int IMAGE_WIDTH_DEF  = 800;
  localparam int IMAGE_HEIGHT_DEF = 800;

  // Shared divider geometry: 41-bit dividend (p << 30 or |diff * i|), 16-bit divisor
  localparam int DVD_W = 41;
  localparam int DVS_W = 16;

  // Config register indexes
  localparam logic [2:0] REG_MAX_ITER   = 3'd0;
  localparam logic [2:0] REG_ESC_LIMIT  = 3'd1;
  localparam logic [2:0] REG_LOW_COL    = 3'd2;
  localparam logic [2:0] REG_HIGH_COL   = 3'd3;
  localparam logic [2:0] REG_INSIDE_COL = 3'd4;
  localparam logic [2:0] REG_STRIDE     = 3'd5;
  localparam logic [2:0] REG_BPP        = 3'd6;

  // Q4.28 limits at 42 bits
  localparam logic signed [41:0] Q_MAX_W = 42'sd2147483647;
  localparam logic signed [41:0] Q_MIN_W = -42'sd2147483648;

  typedef struct packed {
    logic [9:0] pixel_x;
    logic [9:0] pixel_y;
  } pix_in_t;

  typedef struct packed {
    logic [25:0] byte_offset;
    logic [23:0] pixel_color;
    logic        escaped;
    logic [15:0] escape_step;
  } pix_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Clamp to the signed Q4.28 range
  function automatic logic signed [31:0] sat_q(input logic signed [41:0] v);
    logic signed [31:0] r;
    if (v > Q_MAX_W) begin
      r = 32'sh7fffffff;
    end else if (v < Q_MIN_W) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/mep_mul.sv]
// Shared signed 32x32 multiplier with registered product.
`default_nettype none
module mep_mul (
  input  wire logic               clk,
  input  wire logic signed [31:0] a,
  input  wire logic signed [31:0] b,
  output logic signed [63:0]      prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule
`default_nettype wire

[hw/rtl/mep_div.sv]
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
module mep_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [mep_pkg::DVD_W-1:0]  dividend,
  input  wire logic [mep_pkg::DVS_W-1:0]  divisor,
  output logic      [mep_pkg::DVD_W-1:0]  quotient,
  output mep_pkg::div_stat_t              stat
);
  import mep_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);

  logic [CNT_W-1:0] cnt;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_sub;
  logic             fits;

  // quotient doubles as the dividend shift register
  assign rem_sh  = {rem, quotient[DVD_W-1]};
  assign fits    = rem_sh >= {1'b0, dvs};
  assign rem_sub = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= CNT_W'(DVD_W - 1);
      end else if (stat.busy) begin
        if (cnt == '0) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (stat.busy) begin
      quotient <= {quotient[DVD_W-2:0], fits};
      rem      <= fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/mandelbrot_escape_pixel.sv]
// Top level of the escape-time pixel engine: sequencer, registers and result stage.
// Mapping x and y takes two divider passes; each iteration steps through S_SQR, S_SQI, S_CRS and S_CHK.
// An escaped point also passes S_COLM, S_COLD and S_COLW, with one more divider pass, before the result is parked.
// Throughput: one word at a time; the next pixel word is taken once the result is parked.
// Reset (rst, synchronous): control state idle, config registers to their defaults.
// A result word waits in the output register while a new pixel word is already taken.
`default_nettype none
module mandelbrot_escape_pixel #(
  parameter int IMAGE_WIDTH  = mep_pkg::IMAGE_WIDTH_DEF,
  parameter int IMAGE_HEIGHT = mep_pkg::IMAGE_HEIGHT_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // pixel coordinate channel
  input  wire logic              pix_valid,
  output logic                   pix_ready,
  input  wire mep_pkg::pix_in_t  pix,
  // result channel
  output logic                   res_valid,
  input  wire logic              res_ready,
  output mep_pkg::pix_out_t      res,
  // config write channel
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [31:0]       cfg_data
);
  import mep_pkg::*;

  // Sequencer codes
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_OFSA = 4'd1;   // py * stride
  localparam logic [3:0] S_OFSB = 4'd2;   // px * bpp
  localparam logic [3:0] S_OFSC = 4'd3;   // sum offset
  localparam logic [3:0] S_MAPX = 4'd4;   // wait for c_re quotient
  localparam logic [3:0] S_MAPY = 4'd5;   // wait for c_im quotient
  localparam logic [3:0] S_SQR  = 4'd6;   // re * re
  localparam logic [3:0] S_SQI  = 4'd7;   // im * im
  localparam logic [3:0] S_CRS  = 4'd8;   // re * im
  localparam logic [3:0] S_CHK  = 4'd9;   // magnitude test, z update
  localparam logic [3:0] S_COLM = 4'd10;  // (high - low) * step
  localparam logic [3:0] S_COLD = 4'd11;  // start colour divide
  localparam logic [3:0] S_COLW = 4'd12;  // wait for colour quotient
  localparam logic [3:0] S_DONE = 4'd13;  // park result

  // c = q - 2.0 in Q4.28
  localparam logic signed [41:0] MAP_BIAS = 42'sd536870912;

  logic [3:0] state;

  // Config registers
  logic [15:0] max_iter;
  logic [31:0] esc_limit;
  logic [23:0] low_col;
  logic [23:0] high_col;
  logic [23:0] in_col;
  logic [15:0] stride;
  logic [3:0]  bpp;

  // Working registers
  logic [9:0]         px;
  logic [9:0]         py;
  logic [25:0]        ofs;
  logic signed [31:0] cre;
  logic signed [31:0] cim;
  logic signed [31:0] zre;
  logic signed [31:0] zim;
  logic [34:0]        sq_re;
  logic [34:0]        sq_im;
  logic [15:0]        iter;
  logic [23:0]        color;
  logic               esc;
  logic [15:0]        step;
  logic               neg;

  // Shared units
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] prod;
  logic               div_start;
  logic [DVD_W-1:0]   div_dvd;
  logic [DVS_W-1:0]   div_dvs;
  logic [DVD_W-1:0]   div_quo;
  div_stat_t          div_stat;

  // Datapath helpers
  logic signed [24:0] col_diff;
  logic [63:0]        prod_abs;
  logic signed [31:0] c_map;
  logic [35:0]        mag;
  logic [31:0]        mag_sat;
  logic               esc_hit;
  logic               last_iter;
  logic [31:0]        sre_s;
  logic [31:0]        sim_s;
  logic signed [31:0] zre_next;
  logic signed [31:0] zim_next;
  logic [23:0]        col_q;

  assign cfg_ready = 1'b1;
  assign pix_ready = (state == S_IDLE);

  // Config write path
  always_ff @(posedge clk) begin
    if (rst) begin
      max_iter  <= 16'd42;
      esc_limit <= 32'h4000_0000;
      low_col   <= 24'h000000;
      high_col  <= 24'hffffff;
      in_col    <= 24'hff00ff;
      stride    <= 16'd3200;
      bpp       <= 4'd4;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MAX_ITER:   max_iter  <= cfg_data[15:0];
        REG_ESC_LIMIT:  esc_limit <= cfg_data;
        REG_LOW_COL:    low_col   <= cfg_data[23:0];
        REG_HIGH_COL:   high_col  <= cfg_data[23:0];
        REG_INSIDE_COL: in_col    <= cfg_data[23:0];
        REG_STRIDE:     stride    <= cfg_data[15:0];
        REG_BPP:        bpp       <= cfg_data[3:0];
        default: ;      // unused index, ignored
      endcase
    end
  end

  assign col_diff = $signed({1'b0, high_col}) - $signed({1'b0, low_col});

  // Multiplier operand select
  always_comb begin
    unique case (state)
      S_OFSA: begin
        mul_a = $signed({22'd0, py});
        mul_b = $signed({16'd0, stride});
      end
      S_OFSB: begin
        mul_a = $signed({22'd0, px});
        mul_b = $signed({28'd0, bpp});
      end
      S_SQR: begin
        mul_a = zre;
        mul_b = zre;
      end
      S_SQI: begin
        mul_a = zim;
        mul_b = zim;
      end
      S_CRS: begin
        mul_a = zre;
        mul_b = zim;
      end
      S_COLM: begin
        mul_a = {{7{col_diff[24]}}, col_diff};
        mul_b = $signed({16'd0, iter});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  mep_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // Divider: c_re on accept, c_im after c_re, colour after an escape
  assign prod_abs  = prod[63] ? (64'd0 - prod) : prod;
  assign div_start = (state == S_IDLE && pix_valid) ||
                     (state == S_MAPX && div_stat.done) ||
                     (state == S_COLD);

  always_comb begin
    unique case (state)
      S_IDLE: begin
        div_dvd = {1'b0, pix.pixel_x, 30'd0};
        div_dvs = DVS_W'(IMAGE_WIDTH);
      end
      S_MAPX: begin
        div_dvd = {1'b0, py, 30'd0};
        div_dvs = DVS_W'(IMAGE_HEIGHT);
      end
      default: begin
        div_dvd = prod_abs[DVD_W-1:0];
        div_dvs = max_iter;
      end
    endcase
  end

  mep_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  // Quotient to c, only the top side can clip
  assign c_map = sat_q($signed({1'b0, div_quo}) - MAP_BIAS);

  // Escape test on the fresh squares; squares clip to Q_MAX only for the update
  assign mag       = {1'b0, sq_re} + {1'b0, sq_im};
  assign mag_sat   = (|mag[35:32]) ? 32'hffff_ffff : mag[31:0];
  assign esc_hit   = mag_sat > esc_limit;
  assign last_iter = ({1'b0, iter} + 17'd1) == {1'b0, max_iter};
  assign sre_s     = (sq_re > 35'h0_7fff_ffff) ? 32'h7fff_ffff : sq_re[31:0];
  assign sim_s     = (sq_im > 35'h0_7fff_ffff) ? 32'h7fff_ffff : sq_im[31:0];
  assign zre_next  = sat_q($signed({10'd0, sre_s}) - $signed({10'd0, sim_s})
                           + {{10{cre[31]}}, cre});
  // cross term: floor(2*re*im / 2^28) is the product shifted by 27
  assign zim_next  = sat_q({{5{prod[63]}}, prod[63:27]} + {{10{cim[31]}}, cim});

  // Colour quotient never exceeds |high - low|, so 24 bits carry it
  assign col_q = neg ? (24'd0 - div_quo[23:0]) : div_quo[23:0];

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (pix_valid) state <= S_OFSA;
        S_OFSA: state <= S_OFSB;
        S_OFSB: state <= S_OFSC;
        S_OFSC: state <= S_MAPX;
        S_MAPX: if (div_stat.done) state <= S_MAPY;
        S_MAPY: begin
          if (div_stat.done) state <= (max_iter == 16'd0) ? S_DONE : S_SQR;
        end
        S_SQR:  state <= S_SQI;
        S_SQI:  state <= S_CRS;
        S_CRS:  state <= S_CHK;
        S_CHK: begin
          priority if (esc_hit) begin
            state <= S_COLM;
          end else if (last_iter) begin
            state <= S_DONE;
          end else begin
            state <= S_SQR;
          end
        end
        S_COLM: state <= S_COLD;
        S_COLD: state <= S_COLW;
        S_COLW: if (div_stat.done) state <= S_DONE;
        S_DONE: if (!res_valid || res_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        px <= pix.pixel_x;
        py <= pix.pixel_y;
      end
      S_OFSB: ofs <= prod[25:0];
      S_OFSC: ofs <= ofs + prod[25:0];
      S_MAPX: if (div_stat.done) cre <= c_map;
      S_MAPY: begin
        if (div_stat.done) begin
          cim   <= c_map;
          zre   <= cre;     // first step from z = 0 lands on c
          zim   <= c_map;
          iter  <= '0;
          color <= in_col;
          esc   <= 1'b0;
          step  <= max_iter;
        end
      end
      S_SQI: sq_re <= prod[62:28];
      S_CRS: sq_im <= prod[62:28];
      S_CHK: begin
        priority if (esc_hit) begin
          esc  <= 1'b1;
          step <= iter;
        end else if (last_iter) begin
          color <= in_col;
          step  <= max_iter;
        end else begin
          zre  <= zre_next;
          zim  <= zim_next;
          iter <= iter + 1'b1;
        end
      end
      S_COLD: neg <= prod[63];
      S_COLW: if (div_stat.done) color <= low_col + col_q;
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == S_DONE && (!res_valid || res_ready)) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!res_valid || res_ready)) begin
      res.byte_offset <= ofs;
      res.pixel_color <= color;
      res.escaped     <= esc;
      res.escape_step <= step;
    end
  end

`ifndef SYNTHESIS
  // divider must be free when a new division starts
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  // a quotient must land in a state that consumes it
  a_div_used: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_MAPX || state == S_MAPY || state == S_COLW))
    else $error("divider result dropped");

  // a new result word only comes out of the park state
  a_res_src: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == S_DONE)
    else $error("result word raised outside park state");
`endif

endmodule
`default_nettype wire
